[rtl/core/ecsf_pkg.sv]
// ----------------------------------------------------------------------------
// ecsf_pkg
// Shared constants, result type and arithmetic helpers for the edge coverage
// span fill block.
// ----------------------------------------------------------------------------
package ecsf_pkg;

    // Geometry and fixed-point format
    localparam int LINE_WIDTH = 4096;
    localparam int FRAC_BITS  = 16;

    // Field widths
    localparam int X_W   = 12;
    localparam int W_W   = 17;
    localparam int H_W   = 18;
    localparam int COV_W = 17;
    localparam int ACC_W = 32;
    localparam int PRD_W = W_W + 1 + H_W;
    localparam int SUM_W = PRD_W + 1;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Item codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic [COV_W-1:0] coverage;
        logic [X_W-1:0]   repeat_count;
        logic             order_error;
        logic             last_of_item;
    } result_t;

    // Saturate a column to the line
    function automatic logic [X_W-1:0] clamp_col(input logic [X_W-1:0] x);
        if (32'(x) >= 32'(LINE_WIDTH)) begin
            return X_W'(LINE_WIDTH - 1);
        end
        return x;
    endfunction

    // Saturate a wide signed sum to the signed 32-bit range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-ACC_W:0] top;
        top = v[SUM_W-1:ACC_W-1];
        if ((&top) || !(|top)) begin
            return v[ACC_W-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    // min(|v|, one), masked to the output width
    function automatic logic [COV_W-1:0] cover_of(input logic signed [ACC_W-1:0] v);
        logic [ACC_W:0] mag;
        logic [ACC_W:0] one;
        one = (ACC_W+1)'(1) << FRAC_BITS;
        mag = v[ACC_W-1] ? (ACC_W+1)'(-{v[ACC_W-1], v}) : {1'b0, v};
        if (mag > one) begin
            mag = one;
        end
        return mag[COV_W-1:0];
    endfunction

endpackage

[rtl/core/edge_coverage_span_fill.sv]
// ----------------------------------------------------------------------------
// edge_coverage_span_fill
// Scanline coverage accumulation over edge contributions sorted by column.
// ----------------------------------------------------------------------------
// An item is taken into an input register; once the result queue has room,
// one pass of logic (one 18x18 multiply, saturating adds, clamps) updates
// the column, cell and run state and pushes its results into a four-entry
// result queue whose head drives the result port. An item with no result or
// one result moves through at one per cycle while the queue has room; an item
// that closes a cell and a gap pushes two results and, since the result port
// moves one transfer per cycle, a stream of such items is held back by the
// result port once the queue fills. start_x is taken at once and used at
// reset-of-line (end of stream); it does not move the current column until
// then.
module edge_coverage_span_fill (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start_x_we,
    input  logic [ecsf_pkg::X_W-1:0]            start_x,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                op,
    input  logic [ecsf_pkg::X_W-1:0]            edge_x,
    input  logic [ecsf_pkg::W_W-1:0]            area_weight,
    input  logic signed [ecsf_pkg::H_W-1:0]     edge_height,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [ecsf_pkg::COV_W-1:0]          coverage,
    output logic [ecsf_pkg::X_W-1:0]            repeat_count,
    output logic                                order_error,
    output logic                                last_of_item
);

    // Configuration register
    logic [ecsf_pkg::X_W-1:0] start_x_reg;

    // Input register
    logic                                in_vld_reg;
    logic                                op_reg;
    logic [ecsf_pkg::X_W-1:0]            x_reg;
    logic [ecsf_pkg::W_W-1:0]            w_reg;
    logic signed [ecsf_pkg::H_W-1:0]     h_reg;

    // Accumulation state
    logic [ecsf_pkg::X_W-1:0]            prev_x_reg, prev_x_next;
    logic signed [ecsf_pkg::ACC_W-1:0]   span_area_reg, span_area_next;
    logic signed [ecsf_pkg::ACC_W-1:0]   run_cover_reg, run_cover_next;

    // Result queue
    ecsf_pkg::result_t                   q_mem [ecsf_pkg::QDEPTH];
    logic [ecsf_pkg::QPTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [ecsf_pkg::QCNT_W-1:0]         cnt_reg, cnt_next;

    // Datapath signals
    logic                                in_xfer, out_xfer, advance;
    logic [1:0]                          push_n;
    ecsf_pkg::result_t                   res0, res1;
    logic signed [ecsf_pkg::PRD_W-1:0]   prod, wh;
    logic signed [ecsf_pkg::SUM_W-1:0]   wh_ext, h_ext, span_ext, run_ext;
    logic [ecsf_pkg::X_W-1:0]            col, gap;

    // Handshakes
    assign in_xfer    = item_valid && !item_stall;
    assign out_xfer   = result_valid && !result_stall;
    assign item_stall = in_vld_reg && !advance;
    assign advance    = in_vld_reg &&
                        ((ecsf_pkg::QCNT_W+1)'(cnt_reg) + (ecsf_pkg::QCNT_W+1)'(push_n)
                         <= (ecsf_pkg::QCNT_W+1)'(ecsf_pkg::QDEPTH));

    // Single-pass update of state and results
    always_comb
    begin
        col      = ecsf_pkg::clamp_col(x_reg);
        gap      = col - prev_x_reg - ecsf_pkg::X_W'(1);
        prod     = $signed({1'b0, w_reg}) * h_reg;
        wh       = prod >>> ecsf_pkg::FRAC_BITS;
        wh_ext   = ecsf_pkg::SUM_W'(wh);
        h_ext    = ecsf_pkg::SUM_W'(h_reg);
        span_ext = ecsf_pkg::SUM_W'(span_area_reg);
        run_ext  = ecsf_pkg::SUM_W'(run_cover_reg);

        prev_x_next    = prev_x_reg;
        span_area_next = span_area_reg;
        run_cover_next = run_cover_reg;
        push_n         = 2'd0;
        res0 = '{coverage: ecsf_pkg::cover_of(span_area_reg),
                 repeat_count: ecsf_pkg::X_W'(1), order_error: 1'b0, last_of_item: 1'b1};
        res1 = '{coverage: ecsf_pkg::cover_of(run_cover_reg),
                 repeat_count: gap, order_error: 1'b0, last_of_item: 1'b1};

        if (op_reg == ecsf_pkg::OP_END) begin
            // End of stream: flush a nonzero cell, restart the line
            if (span_area_reg != '0) begin
                push_n = 2'd1;
            end
            prev_x_next    = ecsf_pkg::clamp_col(start_x_reg);
            span_area_next = '0;
            run_cover_next = '0;
        end
        else if (col < prev_x_reg) begin
            // Out of order: flag it, state holds
            push_n = 2'd1;
            res0   = '{coverage: '0, repeat_count: '0, order_error: 1'b1, last_of_item: 1'b1};
        end
        else if (col == prev_x_reg) begin
            // Same cell: accumulate
            span_area_next = ecsf_pkg::sat_acc(span_ext + wh_ext);
            run_cover_next = ecsf_pkg::sat_acc(run_ext + h_ext);
        end
        else begin
            // New cell: close the old one, fill the gap with the run
            res0.last_of_item = (gap == '0);
            push_n            = (gap == '0) ? 2'd1 : 2'd2;
            span_area_next    = ecsf_pkg::sat_acc(run_ext + wh_ext);
            run_cover_next    = ecsf_pkg::sat_acc(run_ext + h_ext);
            prev_x_next       = col;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_x_reg   <= '0;
            in_vld_reg    <= 1'b0;
            prev_x_reg    <= ecsf_pkg::clamp_col('0);
            span_area_reg <= '0;
            run_cover_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end
        else begin
            if (start_x_we) begin
                start_x_reg <= start_x;
            end
            if (in_xfer) begin
                in_vld_reg <= 1'b1;
            end
            else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                prev_x_reg    <= prev_x_next;
                span_area_reg <= span_area_next;
                run_cover_reg <= run_cover_next;
                wr_ptr_reg    <= wr_ptr_reg + ecsf_pkg::QPTR_W'(push_n);
            end
            if (out_xfer) begin
                rd_ptr_reg <= rd_ptr_reg + ecsf_pkg::QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (advance) begin
            cnt_next = cnt_next + ecsf_pkg::QCNT_W'(push_n);
        end
        if (out_xfer) begin
            cnt_next = cnt_next - ecsf_pkg::QCNT_W'(1);
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            op_reg <= op;
            x_reg  <= edge_x;
            w_reg  <= area_weight;
            h_reg  <= edge_height;
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (advance && push_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= res0;
        end
        if (advance && push_n == 2'd2) begin
            q_mem[wr_ptr_reg + ecsf_pkg::QPTR_W'(1)] <= res1;
        end
    end

    // Result port from queue head
    assign result_valid = (cnt_reg != '0);
    assign coverage     = q_mem[rd_ptr_reg].coverage;
    assign repeat_count = q_mem[rd_ptr_reg].repeat_count;
    assign order_error  = q_mem[rd_ptr_reg].order_error;
    assign last_of_item = q_mem[rd_ptr_reg].last_of_item;

endmodule
